/* rtl/fmti_pkg.sv */
// ----------------------------------------------------------------------------
// Field map trilinear interpolation package
// Shared constants and types for the grid store and the interpolation datapath.
// ----------------------------------------------------------------------------
package fmti_pkg;

   localparam int GridX = 32;
   localparam int GridY = 32;
   localparam int GridZ = 32;
   localparam int AddrWidth = 15;
   localparam int SampleWidth = 24;
   localparam int WordWidth = 3 * SampleWidth;
   localparam int PosWidth = 32;
   localparam int FracWidth = 16;

   localparam logic [2:0] CSR_CORNER_X = 3'd0;
   localparam logic [2:0] CSR_CORNER_Y = 3'd1;
   localparam logic [2:0] CSR_CORNER_Z = 3'd2;
   localparam logic [2:0] CSR_INV_STEP_X = 3'd3;
   localparam logic [2:0] CSR_INV_STEP_Y = 3'd4;
   localparam logic [2:0] CSR_INV_STEP_Z = 3'd5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic [FracWidth-1:0] frac_type;

   // One linear stage: a*(1-f) + b*f, rounded to nearest with halves up.
   function automatic sample_type mix(input sample_type a, input sample_type b,
                                      input frac_type f);
      logic signed [17:0] wf;
      logic signed [17:0] wg;
      logic signed [41:0] pa;
      logic signed [41:0] pb;
      logic signed [42:0] v;
      logic signed [42:0] r;
      begin
         wf = signed'({2'b00, f});
         wg = 18'sd65536 - wf;
         pa = a * wg;
         pb = b * wf;
         v = 43'(pa) + 43'(pb);
         r = (v + 43'sd32768) >>> 16;
         mix = r[SampleWidth-1:0];
      end
   endfunction

endpackage

/* rtl/fmti_locate.sv */
// ----------------------------------------------------------------------------
// Axis locator
// Registered (pos - corner) * inv_step, giving cell index, weight and in-grid.
// ----------------------------------------------------------------------------
module fmti_locate (
   input  logic        clock,
   input  logic [31:0] pos,
   input  logic [31:0] corner,
   input  logic [31:0] inv_step,
   input  logic [8:0]  limit,
   output logic [7:0]  idx,
   output logic [15:0] frac,
   output logic        in_grid
);

   logic signed [32:0] diff;
   logic [32:0]        mag_in, mag_ff;
   logic               neg_in, neg_ff;
   logic [64:0]        prod;

   assign diff = 33'(signed'(pos)) - 33'(signed'(corner));
   assign neg_in = diff[32];
   assign mag_in = neg_in ? 33'(-diff) : 33'(diff);

   // Magnitude registered before the 33x32 product.
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
   end

   assign prod = 65'(mag_ff) * 65'(inv_step);
   assign idx = prod[47:40];
   assign frac = prod[39:24];
   assign in_grid = !(neg_ff && prod != 65'd0) && (prod[64:40] <= 25'(limit));

endmodule

/* rtl/field_map_trilinear_interp.sv */
// ----------------------------------------------------------------------------
// Field map trilinear interpolation
// Grid of 3D vector samples in one memory, with trilinear lookup.
// ----------------------------------------------------------------------------
// Usage: each req_ beat is a sample write (req_tuser 0) or a position query
// (req_tuser 1). A write is stored at its accepting edge and gives no response.
// A query first locates its cell on each axis (ST_LOC1, ST_LOC2); an outside
// query then answers zeros with rsp_tuser clear. An inside query reads its
// eight corner samples one per cycle in ST_READ, which also catches the final
// read data, then blends along x, y and z in ST_MIX, each level registered,
// and raises rsp_tvalid in ST_OUT. Only one item is in flight: req_tready is
// high only while idle, so a new write or query is taken only once the last
// item is through. The response stays in its register until taken; a stalled
// receiver holds the block and req_tready stays low until the beat leaves.
// Reset returns the control to idle and the configuration registers to their
// defaults; grid contents are undefined until written. csr_ writes take
// effect at once and belong between items.
// ----------------------------------------------------------------------------
module field_map_trilinear_interp (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode
   input  logic         req_tuser,
   // grid_index[14:0], sample_x[38:15], sample_y[62:39], sample_z[86:63],
   // pos_x[118:87], pos_y[150:119], pos_z[182:151]
   input  logic [183:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // inside_res
   output logic         rsp_tuser,
   // field_out_x[23:0], field_out_y[47:24], field_out_z[71:48]
   output logic [71:0]  rsp_tdata,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOC1 = 3'd1;
   localparam logic [2:0] ST_LOC2 = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_MIX  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [31:0] cx_ff, cy_ff, cz_ff, ix_ff, iy_ff, iz_ff;
   logic [2:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [95:0] pos_ff;
   logic [7:0]  gx, gy, gz;
   logic [15:0] fx, fy, fz;
   logic        inx, iny, inz;
   logic [7:0]  gx_ff, gy_ff, gz_ff;
   logic [15:0] fx_ff, fy_ff, fz_ff;
   logic [fmti_pkg::WordWidth-1:0] mem [2**fmti_pkg::AddrWidth];
   logic [fmti_pkg::WordWidth-1:0] rd_ff;
   logic [fmti_pkg::WordWidth-1:0] corner_ff [8];
   logic [fmti_pkg::AddrWidth-1:0] rd_addr;
   logic [2:0]  sel;
   logic [31:0] kx, ky, kz;
   logic        accept;
   logic [71:0] out_ff;
   logic        hit_ff;
   fmti_pkg::sample_type xs [3][4];
   fmti_pkg::sample_type xs_ff [3][4];
   fmti_pkg::sample_type ys [3][2];
   fmti_pkg::sample_type ys_ff [3][2];
   fmti_pkg::sample_type res [3];

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = out_ff;
   assign rsp_tuser = hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
         ix_ff <= 32'd16777216; iy_ff <= 32'd16777216; iz_ff <= 32'd16777216;
      end else if (csr_wen) begin
         unique case (csr_index)
            fmti_pkg::CSR_CORNER_X:   cx_ff <= csr_wdata;
            fmti_pkg::CSR_CORNER_Y:   cy_ff <= csr_wdata;
            fmti_pkg::CSR_CORNER_Z:   cz_ff <= csr_wdata;
            fmti_pkg::CSR_INV_STEP_X: ix_ff <= csr_wdata;
            fmti_pkg::CSR_INV_STEP_Y: iy_ff <= csr_wdata;
            fmti_pkg::CSR_INV_STEP_Z: iz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   fmti_locate u_loc_x (.clock(clock), .pos(pos_ff[31:0]), .corner(cx_ff),
      .inv_step(ix_ff), .limit(9'(fmti_pkg::GridX - 2)), .idx(gx), .frac(fx),
      .in_grid(inx));
   fmti_locate u_loc_y (.clock(clock), .pos(pos_ff[63:32]), .corner(cy_ff),
      .inv_step(iy_ff), .limit(9'(fmti_pkg::GridY - 2)), .idx(gy), .frac(fy),
      .in_grid(iny));
   fmti_locate u_loc_z (.clock(clock), .pos(pos_ff[95:64]), .corner(cz_ff),
      .inv_step(iz_ff), .limit(9'(fmti_pkg::GridZ - 2)), .idx(gz), .frac(fz),
      .in_grid(inz));

   // Corner order follows the count: bit 0 steps x, bit 1 y, bit 2 z.
   assign sel = cnt_ff[2:0];
   assign kx = 32'(gx_ff) + 32'(sel[0]);
   assign ky = 32'(gy_ff) + 32'(sel[1]);
   assign kz = 32'(gz_ff) + 32'(sel[2]);
   assign rd_addr = fmti_pkg::AddrWidth'(kx + fmti_pkg::GridX * ky
                    + fmti_pkg::GridX * fmti_pkg::GridY * kz);

   always_ff @(posedge clock) begin
      if (accept && req_tuser == fmti_pkg::OP_WRITE)
         mem[req_tdata[14:0]] <= req_tdata[86:15];
      rd_ff <= mem[rd_addr];
   end

   // Each level of the blend ends in a register, so only one mix level lies
   // between registers: x first, then y, then z, each in its own ST_MIX step.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int j = 0; j < 4; j++)
            xs[c][j] = fmti_pkg::mix(corner_ff[2*j][c*24 +: 24],
                                     corner_ff[2*j+1][c*24 +: 24], fx_ff);
         for (int j = 0; j < 2; j++)
            ys[c][j] = fmti_pkg::mix(xs_ff[c][2*j], xs_ff[c][2*j+1], fy_ff);
         res[c] = fmti_pkg::mix(ys_ff[c][0], ys_ff[c][1], fz_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && req_tuser == fmti_pkg::OP_QUERY) state_in = ST_LOC1;
         ST_LOC1: state_in = ST_LOC2;
         ST_LOC2: begin
            cnt_in = '0;
            state_in = (inx && iny && inz) ? ST_READ : ST_OUT;
         end
         ST_READ: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               cnt_in = '0;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) state_in = ST_OUT;
         end
         ST_OUT: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      if (accept) pos_ff <= req_tdata[182:87];
      if (state_ff == ST_LOC2) begin
         gx_ff <= gx; gy_ff <= gy; gz_ff <= gz;
         fx_ff <= fx; fy_ff <= fy; fz_ff <= fz;
         out_ff <= '0;
         hit_ff <= 1'b0;
      end
      // Read data arrives in rd_ff in the cycle after its address.
      if (state_ff == ST_READ && cnt_ff != 4'd0)
         corner_ff[3'(cnt_ff - 4'd1)] <= rd_ff;
      if (state_ff == ST_MIX) begin
         xs_ff <= xs;
         ys_ff <= ys;
      end
      if (state_ff == ST_MIX && cnt_ff == 4'd2) begin
         out_ff <= {res[2], res[1], res[0]};
         hit_ff <= 1'b1;
      end
   end

endmodule
